// ===== rtl/bps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the bipartite partition search unit
// Row and count widths, the controller state encoding, the status bundle
// from the row checker and the bit-reversal helper for labelings.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int ROW_WIDTH   = 16;  // adjacency row and side mask width
   localparam int COUNT_WIDTH = 5;   // vertex count and row counter width
   localparam int VTX_WIDTH   = 4;   // vertex index within one row
   localparam int FIELD_LIMIT = 16;  // most vertices a row can describe

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   // outcome of checking one row against the current labeling
   typedef struct packed {
      logic valid;  // a row check completes this cycle
      logic fail;   // an edge joins two vertices on one side
      logic last;   // the checked row is the last vertex
   } chk_status_type;

   // label digit n-1-i maps to vertex i: reverse all bits, shift down later
   function automatic logic [ROW_WIDTH-1:0] reverse_row(input logic [ROW_WIDTH-1:0] value);
      logic [ROW_WIDTH-1:0] rev;
      rev = '0;
      for (int i = 0; i < ROW_WIDTH; i++) begin
         rev[i] = value[ROW_WIDTH-1-i];
      end
      return rev;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bipartite_partition_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: one row per cycle while loading; the row that completes the graph starts
//   the search, or for a one-vertex graph goes straight to the result.
// Search: one row check per cycle through the adjacency memory port, but a failed check restarts the labeling.
// After the search ends, the result passes through the emit state into the output register.
// Synchronous active-high reset resets control state; memory contents are kept.
// ----------------------------------------------------------------------------
// bipartite_partition_search_unit: top level
// Collects adjacency rows, then walks two-sided labelings in order and
// returns the first one with no edge inside either side, or a miss if none.
// ----------------------------------------------------------------------------
module bipartite_partition_search_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: vertex_count
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   // input rows
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] row_bits
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [0] is_bipartite, [16:1] side_mask, [23:17] zero
);
   import bps_pkg::*;

   localparam int CAP   = (MAX_VERTICES < FIELD_LIMIT) ? MAX_VERTICES : FIELD_LIMIT;
   localparam int AW    = $clog2(CAP);

   state_type               state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  vcount_ff, vcount_in;
   logic [COUNT_WIDTH-1:0]  rows_ff, rows_in;
   logic [ROW_WIDTH-1:0]    label_ff, label_in;
   logic [COUNT_WIDTH-1:0]  iss_ff, iss_in;
   logic                    found_ff, found_in;
   logic [ROW_WIDTH-1:0]    res_mask_ff, res_mask_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0]  eff_n;
   logic [ROW_WIDTH-1:0]    full_mask;
   logic [ROW_WIDTH-1:0]    cand_mask;
   logic [COUNT_WIDTH-1:0]  next_rows;
   logic [ROW_WIDTH-1:0]    next_label;
   logic                    req_xfer;
   logic                    wr_en;
   logic                    rd_en;
   chk_status_type          chk;

   // clamp the vertex count to the supported range
   always_comb begin
      if (vcount_ff == '0) begin
         eff_n = COUNT_WIDTH'(1);
      end else if (vcount_ff > COUNT_WIDTH'(CAP)) begin
         eff_n = COUNT_WIDTH'(CAP);
      end else begin
         eff_n = vcount_ff;
      end
      full_mask = ROW_WIDTH'((17'(1) << eff_n) - 17'(1));
      cand_mask = reverse_row(label_ff) >> (COUNT_WIDTH'(FIELD_LIMIT) - eff_n);
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign next_rows  = rows_ff + COUNT_WIDTH'(1);
   assign next_label = label_ff + ROW_WIDTH'(1);
   assign wr_en      = req_xfer && (rows_ff < COUNT_WIDTH'(CAP));
   assign rd_en      = (state_ff == ST_SEARCH) && (iss_ff < eff_n)
                       && !(chk.valid && (chk.fail || chk.last));

   bps_row_check #(
      .DEPTH (CAP)
   ) u_row_check (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (rows_ff[AW-1:0]),
      .wr_data   (req_tdata),
      .rd_en     (rd_en),
      .rd_vtx    (iss_ff[VTX_WIDTH-1:0]),
      .cand_mask (cand_mask),
      .full_mask (full_mask),
      .vtx_count (eff_n),
      .status    (chk)
   );

   // sequence load, search and hand-off of the result
   always_comb begin
      state_in     = state_ff;
      vcount_in    = csr_we ? csr_wdata : vcount_ff;
      rows_in      = rows_ff;
      label_in     = label_ff;
      iss_in       = rd_en ? iss_ff + COUNT_WIDTH'(1) : iss_ff;
      found_in     = found_ff;
      res_mask_in  = res_mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (next_rows < eff_n) begin
                  rows_in = next_rows;
               end else begin
                  rows_in  = '0;
                  label_in = ROW_WIDTH'(1);
                  iss_in   = '0;
                  if (eff_n == COUNT_WIDTH'(1)) begin
                     found_in    = 1'b0;
                     res_mask_in = '0;
                     state_in    = ST_EMIT;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (chk.valid && chk.fail) begin
               // reject this labeling, restart at the first row
               iss_in = '0;
               if (next_label == full_mask) begin
                  found_in    = 1'b0;
                  res_mask_in = '0;
                  state_in    = ST_EMIT;
               end else begin
                  label_in = next_label;
               end
            end else if (chk.valid && chk.last) begin
               found_in    = 1'b1;
               res_mask_in = cand_mask;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, res_mask_ff, found_ff};
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         vcount_ff    <= COUNT_WIDTH'(16);
         rows_ff      <= '0;
         label_ff     <= '0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rows_ff      <= rows_in;
         label_ff     <= label_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      res_mask_ff <= res_mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the search only walks labelings strictly between all-zero and all-one
   a_label_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (label_ff != '0 && label_ff < full_mask))
      else $error("labeling outside the search range");

   // no row check is in flight outside the search
   a_no_stray_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SEARCH) |-> !chk.valid)
      else $error("row check outside the search");

   // a miss carries an empty mask, a hit a mask with both sides populated
   a_miss_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |-> (rsp_data_ff[16:1] == '0))
      else $error("mask set without a valid split");

   a_hit_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && found_ff) |-> (res_mask_ff != '0 && res_mask_ff != full_mask))
      else $error("trivial split reported");

endmodule
`default_nettype wire

// ===== rtl/bps_row_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_row_check: adjacency memory and per-row edge check
// Holds the adjacency rows in a synchronous memory with a registered read
// port and tests each row read back against the candidate side mask.
// ----------------------------------------------------------------------------
module bps_row_check #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  wire logic [bps_pkg::ROW_WIDTH-1:0]       wr_data,
   input  wire logic                                rd_en,
   input  wire logic [bps_pkg::VTX_WIDTH-1:0]       rd_vtx,
   input  wire logic [bps_pkg::ROW_WIDTH-1:0]       cand_mask,
   input  wire logic [bps_pkg::ROW_WIDTH-1:0]       full_mask,
   input  wire logic [bps_pkg::COUNT_WIDTH-1:0]     vtx_count,
   output bps_pkg::chk_status_type                  status
);
   import bps_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [ROW_WIDTH-1:0] mem [DEPTH];
   logic [ROW_WIDTH-1:0] rd_data_ff;
   logic                 chk_valid_ff;
   logic                 chk_valid_in;
   logic [VTX_WIDTH-1:0] chk_vtx_ff;
   logic [ROW_WIDTH-1:0] low_mask;
   logic [ROW_WIDTH-1:0] above_mask;
   logic [ROW_WIDTH-1:0] group_mask;

   // write a loaded row, read one row per cycle while the search issues reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_vtx[AW-1:0]];
         chk_vtx_ff <= rd_vtx;
      end
   end

   assign chk_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else begin
         chk_valid_ff <= chk_valid_in;
      end
   end

   // keep only partners above the checked vertex and on its own side
   always_comb begin
      low_mask   = ROW_WIDTH'((17'(2) << chk_vtx_ff) - 17'(1));
      above_mask = full_mask & ~low_mask;
      group_mask = cand_mask[chk_vtx_ff] ? cand_mask : (full_mask & ~cand_mask);
   end

   assign status.valid = chk_valid_ff;
   assign status.fail  = |(rd_data_ff & group_mask & above_mask);
   assign status.last  = (COUNT_WIDTH'(chk_vtx_ff) == (vtx_count - COUNT_WIDTH'(1)));

endmodule
`default_nettype wire
